@@ rtl/isr_pkg.sv @@
// Package for the ISO-TP receive reassembler: transaction types, command codes
// and back-end state codes shared by all modules. No dependencies.
package isr_pkg;

   typedef struct packed {
      logic [10:0] can_id;
      logic        is_extended;
      logic        is_remote;
      logic [3:0]  dlc;
      logic [63:0] data_bytes;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        overflow;
      logic [7:0]  payload_length;
      logic [3:0]  chunk_index;
      logic [63:0] chunk_data;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SINGLE,
      OP_FIRST_OK,
      OP_FIRST_BAD,
      OP_CONSEC
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  nib;
      logic [63:0] data;
   } cmd_type;

   typedef struct packed {
      logic        receiving;
      logic        over_count;
   } bk_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WRLO,
      BK_WRHI,
      BK_RDREQ,
      BK_RDOUT,
      BK_EMIT
   } bk_state_type;

   localparam logic [7:0] PCI_SINGLE  = 8'h00;
   localparam logic [7:0] PCI_FIRST   = 8'h10;
   localparam logic [7:0] PCI_CONSEC  = 8'h20;
   localparam logic [7:0] PCI_FLOWCTL = 8'h30;
   localparam logic [7:0] TYPE_MASK   = 8'hF0;
   localparam logic [3:0] FC_CONTINUE = 4'h0;
   localparam logic [3:0] FC_OVERFLOW = 4'h2;
   localparam logic       KIND_FC     = 1'b0;
   localparam logic       KIND_CHUNK  = 1'b1;

endpackage

@@ rtl/isr_front.sv @@
// Front end: filters incoming frames and classifies them into commands.
// Depends on isr_pkg.
module isr_front #(
   parameter int MAX_PAYLOAD = 128
) (
   input  isr_pkg::req_type req_data,
   input  logic [10:0]      request_id,
   output logic             keep,
   output isr_pkg::cmd_type cmd
);
   import isr_pkg::*;

   logic [7:0]  b0;
   logic [11:0] total;
   logic [63:0] single_data;

   always_comb begin
      b0 = req_data.data_bytes[7:0];
      total = {b0[3:0], req_data.data_bytes[15:8]};
      single_data = '0;
      for (int k = 0; k < 7; k++) begin
         if (4'(k) < b0[3:0]) begin
            single_data[8*k +: 8] = req_data.data_bytes[8*(k+1) +: 8];
         end
      end
      keep = 1'b0;
      cmd.op = OP_CONSEC;
      cmd.nib = b0[3:0];
      cmd.data = req_data.data_bytes;
      if (!req_data.is_extended && !req_data.is_remote && req_data.can_id == request_id) begin
         case (b0 & TYPE_MASK)
            PCI_SINGLE: begin
               if (b0[3:0] != 4'd0 && b0[3:0] <= 4'd7 && req_data.dlc > b0[3:0]) begin
                  keep = 1'b1;
                  cmd.op = OP_SINGLE;
                  cmd.data = single_data;
               end
            end
            PCI_FIRST: begin
               keep = 1'b1;
               if (total > 12'd7 && 32'(total) <= MAX_PAYLOAD) begin
                  cmd.op = OP_FIRST_OK;
               end else begin
                  cmd.op = OP_FIRST_BAD;
               end
            end
            PCI_CONSEC: begin
               keep = 1'b1;
               cmd.op = OP_CONSEC;
            end
            default: keep = 1'b0;
         endcase
      end
   end

endmodule

@@ rtl/isr_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on isr_pkg.
module isr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  isr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output isr_pkg::cmd_type pop_cmd,
   output logic [1:0]       count
);
   import isr_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full = count_ff == 2'd2;
      not_empty = count_ff != 2'd0;
      pop_cmd = slot_ff[rptr_ff];
      count = count_ff;
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/isr_back.sv @@
// Back end: reassembly state, row-organized payload memory and result register.
// Depends on isr_pkg.
module isr_back #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  isr_pkg::cmd_type       cmd,
   output logic                   cmd_pop,
   input  logic [7:0]             fc_separation_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output isr_pkg::rsp_type       rsp_data,
   output isr_pkg::bk_status_type status
);
   import isr_pkg::*;

   localparam int TOT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int ROWS  = (MAX_PAYLOAD + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   bk_state_type state_ff, state_in;
   logic             receiving_ff, receiving_in;
   logic [TOT_W-1:0] total_ff, total_in, recv_ff, recv_in;
   logic [3:0]       seq_ff, seq_in, idx_ff, idx_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [127:0]     wdat_ff, wdat_in;
   logic [15:0]      wen_ff, wen_in;
   logic             done_ff, done_in;
   rsp_type          pend_ff, pend_in, out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [63:0]      mem [ROWS];
   logic [63:0]      rd_data_ff;
   logic [ROW_W-1:0] rd_row, wr_row;
   logic [7:0]       wr_be;
   logic [63:0]      wr_data;
   logic             out_free;
   logic [TOT_W-1:0] remain, new_recv;
   logic [2:0]       chunk;
   logic [55:0]      masked;
   logic [6:0]       en7;
   logic [TOT_W:0]   rows_used;
   logic [3:0]       last_idx;
   logic [63:0]      chunk_out;
   logic [6:0]       pos;
   logic [63:0]      fc_word;

   always_comb begin
      state_in = state_ff;
      receiving_in = receiving_ff;
      total_in = total_ff;
      recv_in = recv_ff;
      seq_in = seq_ff;
      idx_in = idx_ff;
      row_in = row_ff;
      wdat_in = wdat_ff;
      wen_in = wen_ff;
      done_in = done_ff;
      pend_in = pend_ff;
      out_in = out_ff;
      cmd_pop = 1'b0;
      wr_row = row_ff;
      wr_be = 8'h00;
      wr_data = wdat_ff[63:0];
      rd_row = ROW_W'(idx_ff);
      out_free = !out_valid_ff || rsp_ready;
      out_valid_in = out_valid_ff && !rsp_ready;

      remain = total_ff - recv_ff;
      chunk = (remain > TOT_W'(7)) ? 3'd7 : remain[2:0];
      masked = '0;
      en7 = '0;
      for (int k = 0; k < 7; k++) begin
         if (3'(k) < chunk) begin
            masked[8*k +: 8] = cmd.data[8*(k+1) +: 8];
            en7[k] = 1'b1;
         end
      end
      new_recv = recv_ff + TOT_W'(chunk);

      rows_used = ((TOT_W+1)'(total_ff) + (TOT_W+1)'(7)) >> 3;
      last_idx = (rows_used > (TOT_W+1)'(16)) ? 4'd15 : 4'(rows_used - 1'b1);
      chunk_out = '0;
      for (int k = 0; k < 8; k++) begin
         pos = {idx_ff, 3'(k)};
         if (32'(pos) < 32'(total_ff)) begin
            chunk_out[8*k +: 8] = rd_data_ff[8*k +: 8];
         end
      end
      fc_word = {40'd0, fc_separation_time, 8'd0, PCI_FLOWCTL};

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               pend_in = '0;
               pend_in.last = 1'b1;
               case (cmd.op)
                  OP_SINGLE: begin
                     pend_in.kind = KIND_CHUNK;
                     pend_in.payload_length = {4'd0, cmd.nib};
                     pend_in.chunk_data = cmd.data;
                     state_in = BK_EMIT;
                  end
                  OP_FIRST_OK: begin
                     pend_in.kind = KIND_FC;
                     pend_in.chunk_data = fc_word | 64'(FC_CONTINUE);
                     receiving_in = 1'b1;
                     total_in = TOT_W'({cmd.nib, cmd.data[15:8]});
                     recv_in = TOT_W'(6);
                     seq_in = 4'd1;
                     wr_row = '0;
                     wr_be = 8'h3F;
                     wr_data = {16'd0, cmd.data[63:16]};
                     state_in = BK_EMIT;
                  end
                  OP_FIRST_BAD: begin
                     pend_in.kind = KIND_FC;
                     pend_in.overflow = 1'b1;
                     pend_in.chunk_data = fc_word | 64'(FC_OVERFLOW);
                     state_in = BK_EMIT;
                  end
                  OP_CONSEC: begin
                     if (receiving_ff) begin
                        if (cmd.nib != seq_ff) begin
                           receiving_in = 1'b0;
                        end else begin
                           wdat_in = {72'd0, masked} << {recv_ff[2:0], 3'b000};
                           wen_in = {9'd0, en7} << recv_ff[2:0];
                           row_in = ROW_W'(recv_ff >> 3);
                           recv_in = new_recv;
                           seq_in = seq_ff + 4'd1;
                           done_in = new_recv >= total_ff;
                           state_in = BK_WRLO;
                        end
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_WRLO: begin
            wr_be = wen_ff[7:0];
            wr_data = wdat_ff[63:0];
            state_in = BK_WRHI;
         end
         BK_WRHI: begin
            wr_row = row_ff + 1'b1;
            wr_be = wen_ff[15:8];
            wr_data = wdat_ff[127:64];
            idx_in = 4'd0;
            if (done_ff) begin
               receiving_in = 1'b0;
               state_in = BK_RDREQ;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_RDREQ: state_in = BK_RDOUT;
         BK_RDOUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind = KIND_CHUNK;
               out_in.overflow = 1'b0;
               out_in.payload_length = 8'(total_ff);
               out_in.chunk_index = idx_ff;
               out_in.chunk_data = chunk_out;
               out_in.last = idx_ff == last_idx;
               idx_in = idx_ff + 4'd1;
               state_in = (idx_ff == last_idx) ? BK_IDLE : BK_RDREQ;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = pend_ff;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      rsp_valid = out_valid_ff;
      rsp_data = out_ff;
      status.receiving = receiving_ff;
      status.over_count = recv_ff > total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         receiving_ff <= 1'b0;
         total_ff <= '0;
         recv_ff <= '0;
         seq_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         receiving_ff <= receiving_in;
         total_ff <= total_in;
         recv_ff <= recv_in;
         seq_ff <= seq_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      row_ff <= row_in;
      wdat_ff <= wdat_in;
      wen_ff <= wen_in;
      done_ff <= done_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 8; b++) begin
         if (wr_be[b]) begin
            mem[wr_row][8*b +: 8] <= wr_data[8*b +: 8];
         end
      end
      rd_data_ff <= mem[rd_row];
   end

endmodule

@@ rtl/isotp_receive_reassembler.sv @@
// Top level of the ISO-TP receive reassembler: configuration registers,
// front end, command queue and back end. Depends on isr_pkg and all isr_ modules.
//
// Usage: CAN frames enter as transactions on the req_ channel (valid/ready).
// Frames that are extended, remote or not on request_id are dropped at once.
// Single frames give one payload transaction, first frames give one flow-control
// transaction, and the consecutive frame that completes a message gives one
// transaction per 8-byte chunk on the rsp_ channel, the final one marked last.
// The front end takes one frame per cycle into a two-entry queue while the queue
// is not full. The back end takes a single or first frame through IDLE and EMIT,
// a consecutive frame through IDLE, WRLO and WRHI (two row writes into the payload
// memory), and each chunk through RDREQ and RDOUT around the registered memory
// read. Results reach rsp_ in the cycle after they are formed, through an output
// register that loads while the previous transaction is taken. When rsp_ready
// stays low, the back end holds, the queue fills and req_ready falls. Reset
// clears back-end state, counters and queue pointers, not the payload memory,
// and loads request_id 0x7E0 and separation time 5. The APB port (psel...pready)
// writes request_id at 0x0 and the separation time at 0x4; pready is always high.
module isotp_receive_reassembler #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  isr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output isr_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import isr_pkg::*;

   logic [10:0] request_id_ff, request_id_in;
   logic [7:0]  fc_sep_ff, fc_sep_in;
   logic        keep, full, push, pop, not_empty;
   cmd_type     front_cmd, back_cmd;
   logic [1:0]  q_count;
   bk_status_type status;

   always_comb begin
      pready = 1'b1;
      request_id_in = request_id_ff;
      fc_sep_in = fc_sep_ff;
      if (psel && penable && pwrite) begin
         if (paddr[2]) begin
            fc_sep_in = pwdata[7:0];
         end else begin
            request_id_in = pwdata[10:0];
         end
      end
      prdata = paddr[2] ? {24'd0, fc_sep_ff} : {21'd0, request_id_ff};
      req_ready = !full;
      push = req_valid && !full && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_id_ff <= 11'h7E0;
         fc_sep_ff <= 8'd5;
      end else begin
         request_id_ff <= request_id_in;
         fc_sep_ff <= fc_sep_in;
      end
   end

   isr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .req_data   (req_data),
      .request_id (request_id_ff),
      .keep       (keep),
      .cmd        (front_cmd)
   );

   isr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_cmd   (back_cmd),
      .count     (q_count)
   );

   isr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (not_empty),
      .cmd                (back_cmd),
      .cmd_pop            (pop),
      .fc_separation_time (fc_sep_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .status             (status)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3) else $error("command queue count out of range");

   a_recv_bound: assert property (@(posedge clock) disable iff (reset)
      status.receiving |-> !status.over_count)
      else $error("received byte count passed the message total");

   a_fc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FC |->
         rsp_data.last && rsp_data.chunk_index == 4'd0 && rsp_data.payload_length == 8'd0)
      else $error("flow-control transaction malformed");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("command popped from an empty queue");

endmodule

@@ verif/tb_top.sv @@
// Testbench for the ISO-TP receive reassembler: random and directed CAN frames in,
// flow-control and payload-chunk transactions checked against a built-in predictor.
// Depends on isr_pkg and the isotp_receive_reassembler RTL.
module tb_top;
   import isr_pkg::*;

   class reassembly_scoreboard;
      logic [10:0] request_id;
      logic [7:0]  sep_time;
      bit          receiving;
      int          exp_total;
      int          got;
      logic [3:0]  exp_seq;
      logic [7:0]  store [128];
      rsp_type     pending [$];
      int          errors;

      function new();
         request_id = 11'h7E0;
         sep_time = 8'd5;
         receiving = 0;
         exp_total = 0;
         got = 0;
         exp_seq = 0;
         errors = 0;
      endfunction

      function void push(logic kind, logic ovf, logic [7:0] len, logic [3:0] idx,
                         logic [63:0] data, logic last);
         rsp_type r;
         r.kind = kind;
         r.overflow = ovf;
         r.payload_length = len;
         r.chunk_index = idx;
         r.chunk_data = data;
         r.last = last;
         pending.push_back(r);
      endfunction

      function void push_flow_control(logic [3:0] status);
         logic [63:0] d;
         d = 64'(PCI_FLOWCTL | 8'(status)) | (64'(sep_time) << 16);
         push(KIND_FC, status == FC_OVERFLOW, 8'd0, 4'd0, d, 1'b1);
      endfunction

      function void note_frame(req_type f);
         logic [7:0]  b0;
         logic [63:0] d;
         int          len;
         int          total;
         int          chunk;
         int          nres;
         if (f.is_extended || f.is_remote || f.can_id != request_id) return;
         b0 = f.data_bytes[7:0];
         if ((b0 & TYPE_MASK) == PCI_SINGLE) begin
            len = b0[3:0];
            if (len == 0 || len > 7 || f.dlc < len + 1) return;
            d = 0;
            for (int k = 0; k < len; k++) d[8*k +: 8] = f.data_bytes[8*(k+1) +: 8];
            push(KIND_CHUNK, 1'b0, 8'(len), 4'd0, d, 1'b1);
         end else if ((b0 & TYPE_MASK) == PCI_FIRST) begin
            total = {b0[3:0], f.data_bytes[15:8]};
            if (total <= 7 || total > 128) begin
               push_flow_control(FC_OVERFLOW);
               return;
            end
            receiving = 1;
            exp_total = total;
            got = 6;
            exp_seq = 1;
            for (int k = 0; k < 6; k++) store[k] = f.data_bytes[8*(k+2) +: 8];
            push_flow_control(FC_CONTINUE);
         end else if ((b0 & TYPE_MASK) == PCI_CONSEC && receiving) begin
            if (b0[3:0] != exp_seq) begin
               receiving = 0;
               return;
            end
            chunk = exp_total > got ? exp_total - got : 0;
            if (chunk > 7) chunk = 7;
            for (int k = 0; k < chunk; k++) store[got+k] = f.data_bytes[8*(k+1) +: 8];
            got += chunk;
            exp_seq = exp_seq + 1;
            if (got < exp_total) return;
            receiving = 0;
            nres = (exp_total + 7) / 8;
            for (int i = 0; i < nres; i++) begin
               d = 0;
               for (int k = 0; k < 8; k++)
                  if (8*i + k < exp_total) d[8*k +: 8] = store[8*i + k];
               push(KIND_CHUNK, 1'b0, 8'(exp_total), 4'(i), d, i + 1 == nres);
            end
         end
      endfunction

      function void check_chunk(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected transaction: %p", r);
            return;
         end
         e = pending.pop_front();
         if (r.kind !== e.kind || r.overflow !== e.overflow
             || r.payload_length !== e.payload_length || r.chunk_index !== e.chunk_index
             || r.chunk_data !== e.chunk_data || r.last !== e.last) begin
            errors++;
            if (errors <= 10) $display("Expected %p, got %p", e, r);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   reassembly_scoreboard sb = new();
   bit idle_on = 1;
   int stall_left = 0;
   int quiet_cycles = 0;
   int frames_sent = 0;

   localparam logic [2:0] ADDR_REQUEST_ID = 3'd0;
   localparam logic [2:0] ADDR_SEP_TIME   = 3'd4;

   isotp_receive_reassembler i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_ready <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_chunk(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 20000) begin
         $display("isotp_receive_reassembler: mismatch");
         $finish;
      end
   end

   task automatic send_frame(input req_type f);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= f;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(f);
      frames_sent++;
   endtask

   function automatic req_type make_frame(logic [10:0] id, logic [7:0] b0, logic [3:0] dlc);
      req_type f;
      f.can_id = id;
      f.is_extended = 0;
      f.is_remote = 0;
      f.dlc = dlc;
      f.data_bytes = {$urandom, $urandom};
      f.data_bytes[7:0] = b0;
      return f;
   endfunction

   task automatic send_first(input int total);
      req_type f;
      f = make_frame(sb.request_id, PCI_FIRST | 8'(total >> 8), 4'd8);
      f.data_bytes[15:8] = total[7:0];
      send_frame(f);
   endtask

   task automatic send_noise();
      req_type f;
      f = make_frame(11'($urandom), 8'($urandom), 4'($urandom_range(0, 8)));
      case ($urandom_range(0, 3))
         0: f.is_extended = 1;
         1: f.is_remote = 1;
         2: f.can_id = sb.request_id;
         default: ;
      endcase
      send_frame(f);
   endtask

   task automatic send_message(input int total, input bit corrupt);
      int ncf;
      int bad;
      logic [3:0] seq;
      send_first(total);
      ncf = (total - 6 + 6) / 7;
      bad = corrupt ? $urandom_range(0, ncf - 1) : -1;
      seq = 1;
      for (int i = 0; i < ncf; i++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         if (i == bad) begin
            send_frame(make_frame(sb.request_id,
                                  PCI_CONSEC | 8'(4'(seq + $urandom_range(1, 15))),
                                  4'($urandom_range(0, 8))));
            return;
         end
         send_frame(make_frame(sb.request_id, PCI_CONSEC | 8'(seq), 4'($urandom_range(0, 8))));
         seq = seq + 1;
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (addr == ADDR_REQUEST_ID) sb.request_id = value[10:0];
      else sb.sep_time = value[7:0];
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      req_type f;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed frames with the reset configuration.
      for (int len = 0; len <= 9; len++)
         send_frame(make_frame(sb.request_id, PCI_SINGLE | 8'(len), 4'd8));
      send_frame(make_frame(sb.request_id, PCI_SINGLE | 8'd7, 4'd7));
      send_frame(make_frame(sb.request_id, PCI_SINGLE | 8'd1, 4'd0));
      send_first(7);
      send_first(129);
      send_first(12'hFFF);
      send_frame(make_frame(sb.request_id, PCI_CONSEC | 8'd1, 4'd8));
      send_frame(make_frame(sb.request_id, PCI_FLOWCTL, 4'd8));
      send_frame(make_frame(sb.request_id, 8'hF5, 4'd8));
      f = make_frame(sb.request_id, PCI_SINGLE | 8'd3, 4'd8);
      f.is_extended = 1;
      send_frame(f);
      f.is_extended = 0;
      f.is_remote = 1;
      send_frame(f);
      send_frame(make_frame(sb.request_id ^ 11'h1, PCI_SINGLE | 8'd3, 4'd8));
      send_first(20);
      send_message(8, 0);
      send_message(40, 1);
      send_message(128, 0);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin csr_write(ADDR_REQUEST_ID, 32'h0);   csr_write(ADDR_SEP_TIME, 32'h0); end
            1: begin csr_write(ADDR_REQUEST_ID, 32'h7FF); csr_write(ADDR_SEP_TIME, 32'hFF); end
            4: begin csr_write(ADDR_REQUEST_ID, 32'h7E0); csr_write(ADDR_SEP_TIME, 32'h5); end
            default: begin
               csr_write(ADDR_REQUEST_ID, $urandom_range(0, 2047));
               csr_write(ADDR_SEP_TIME, $urandom_range(0, 255));
            end
         endcase
         if (phase == 4) idle_on = 0;
         while (frames_sent < 60 + 42 * (phase + 1)) begin
            case ($urandom_range(0, 9))
               0: send_noise();
               1: send_frame(make_frame(sb.request_id, PCI_SINGLE | 8'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 8))));
               2: send_first($urandom_range(0, 4095));
               default: send_message($urandom_range(0, 7) == 0 ? $urandom_range(100, 128)
                                     : $urandom_range(8, 40), $urandom_range(0, 4) == 0);
            endcase
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("isotp_receive_reassembler: match");
      end else begin
         $display("isotp_receive_reassembler: mismatch");
      end
      $finish;
   end
endmodule
